// ===== hdl/lzwmf_pkg.sv =====
// Package for the LZ window match finder: widths, codes, state type.
// No dependencies.
package lzwmf_pkg;
   localparam int PosW = 16;
   localparam int WinDepth = 65536;
   localparam int LinkW = 17;
   localparam int MaxLook = 256;
   localparam int LookW = 8;
   localparam int CntW = 9;
   localparam int LenW = 9;
   localparam logic [1:0] ModeWrUpd = 2'd0;
   localparam logic [1:0] ModeWrRaw = 2'd1;
   localparam logic [1:0] ModeSearch = 2'd2;
   localparam logic [1:0] ModeRead = 2'd3;
   localparam logic KindRead = 1'b0;
   localparam logic KindSearch = 1'b1;

   typedef enum logic [20:0] {
      ST_CLEAR = 21'h000001,
      ST_IDLE  = 21'h000002,
      ST_WU1   = 21'h000004,
      ST_WU2   = 21'h000008,
      ST_WU3   = 21'h000010,
      ST_WU4   = 21'h000020,
      ST_WU5   = 21'h000040,
      ST_WU6   = 21'h000080,
      ST_RD1   = 21'h000100,
      ST_RD2   = 21'h000200,
      ST_SR1   = 21'h000400,
      ST_SR2   = 21'h000800,
      ST_SR3   = 21'h001000,
      ST_SR4   = 21'h002000,
      ST_SR5   = 21'h004000,
      ST_SR6   = 21'h008000,
      ST_SR7   = 21'h010000,
      ST_SR8   = 21'h020000,
      ST_SR9   = 21'h040000,
      ST_SRA   = 21'h080000,
      ST_DONE  = 21'h100000
   } state_type;
endpackage

// ===== hdl/lz_window_match_finder.sv =====
// Top level of the LZ window match finder: sequencer over five RAMs.
// Depends on lzwmf_pkg and lzwmf_ram.
//
// After reset the block is busy while it clears the window,
// link, head and tail memories, one entry per cycle. A write without update
// or a search byte with last low leaves the block idle and ready for the
// next transaction; a write with update, a read and a search byte with last
// high keep it busy. A search of fewer than 3 bytes walks no chain. A longer
// search walks the hash chain node by node and compares further bytes at a
// node only when the first compared byte agrees; a node that matches the
// whole string ends the walk. Each memory has a single read port.
// A result appears on rsp_valid for one cycle and is not held; the
// receiver cannot stall. busy stays high until the result has been shown.
module lz_window_match_finder
   import lzwmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last,
   input  logic [PosW-1:0]   req_read_index,
   output logic              rsp_valid,
   output logic              rsp_result_kind,
   output logic [7:0]        rsp_read_byte,
   output logic [LenW-1:0]   rsp_match_length,
   output logic [PosW-1:0]   rsp_match_offset
);
   state_type state_ff, state_in;
   logic [PosW-1:0] clr_ff, clr_in;
   logic [PosW-1:0] oldest_ff, oldest_in, newest_ff, newest_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [7:0]      b_ff, b_in;
   logic [PosW-1:0] key_ff, key_in;
   logic [LinkW-1:0] c_ff, c_in;
   logic [PosW:0]   steps_ff, steps_in;
   logic [CntW-1:0] len_ff, len_in, cl_ff, cl_in;
   logic [PosW-1:0] off_ff, off_in;
   logic [7:0]      lo_ff, lo_in;
   logic            kind_ff, kind_in;
   logic [7:0]      rbyte_ff, rbyte_in;

   logic w_we, l_we, h_we, t_we, k_we;
   logic [PosW-1:0] w_wa, w_ra, l_wa, l_ra, h_wa, h_ra, t_wa, t_ra;
   logic [7:0] w_wd, w_rd, k_wd, k_rd;
   logic [LinkW-1:0] l_wd, l_rd, h_wd, h_rd;
   logic [PosW-1:0] t_wd, t_rd;
   logic [LookW-1:0] k_wa, k_ra;

   lzwmf_ram #(.Width(8), .Depth(WinDepth)) u_win (.clock, .wr_en(w_we),
      .wr_addr(w_wa), .wr_data(w_wd), .rd_addr(w_ra), .rd_data(w_rd));
   lzwmf_ram #(.Width(LinkW), .Depth(WinDepth)) u_link (.clock, .wr_en(l_we),
      .wr_addr(l_wa), .wr_data(l_wd), .rd_addr(l_ra), .rd_data(l_rd));
   lzwmf_ram #(.Width(LinkW), .Depth(WinDepth)) u_head (.clock, .wr_en(h_we),
      .wr_addr(h_wa), .wr_data(h_wd), .rd_addr(h_ra), .rd_data(h_rd));
   lzwmf_ram #(.Width(PosW), .Depth(WinDepth)) u_tail (.clock, .wr_en(t_we),
      .wr_addr(t_wa), .wr_data(t_wd), .rd_addr(t_ra), .rd_data(t_rd));
   lzwmf_ram #(.Width(8), .Depth(MaxLook)) u_look (.clock, .wr_en(k_we),
      .wr_addr(k_wa), .wr_data(k_wd), .rd_addr(k_ra), .rd_data(k_rd));

   localparam logic [LinkW-1:0] LinkNone = LinkW'(WinDepth);

   logic accept;
   logic [CntW-1:0] idx;
   logic [PosW-1:0] cpos;
   logic [7:0]      new_lo;
   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign cpos = c_ff[PosW-1:0];
   // forward the byte just stored when the newest position is the one overwritten
   assign new_lo = (newest_ff == oldest_ff) ? b_ff : w_rd;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; oldest_in = oldest_ff;
      newest_in = newest_ff; cnt_in = cnt_ff; b_in = b_ff; key_in = key_ff;
      c_in = c_ff; steps_in = steps_ff; len_in = len_ff; cl_in = cl_ff;
      off_in = off_ff; lo_in = lo_ff; kind_in = kind_ff; rbyte_in = rbyte_ff;
      w_we = 1'b0; l_we = 1'b0; h_we = 1'b0; t_we = 1'b0; k_we = 1'b0;
      w_wa = oldest_ff; w_wd = b_ff; w_ra = oldest_ff;
      l_wa = oldest_ff; l_wd = LinkNone; l_ra = oldest_ff;
      h_wa = key_ff; h_wd = l_rd; h_ra = key_ff;
      t_wa = key_ff; t_wd = newest_ff; t_ra = key_ff;
      k_wa = cnt_ff[LookW-1:0]; k_wd = req_data_byte; k_ra = '0;
      idx = '0;
      case (state_ff)
         ST_CLEAR: begin
            w_we = 1'b1; w_wa = clr_ff; w_wd = '0;
            l_we = 1'b1; l_wa = clr_ff;
            h_we = 1'b1; h_wa = clr_ff; h_wd = LinkNone;
            t_we = 1'b1; t_wa = clr_ff; t_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               b_in = req_data_byte;
               case (req_mode)
                  ModeWrUpd: begin
                     w_ra = oldest_ff; state_in = ST_WU1;
                  end
                  ModeWrRaw: begin
                     w_we = 1'b1; w_wd = req_data_byte;
                     oldest_in = oldest_ff + 1'b1;
                  end
                  ModeSearch: begin
                     if (cnt_ff < CntW'(MaxLook)) begin
                        k_we = 1'b1; cnt_in = cnt_ff + 1'b1;
                     end
                     if (req_last) state_in = ST_SR1;
                  end
                  ModeRead: begin
                     w_ra = req_read_index + oldest_ff; state_in = ST_RD1;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD1: begin
            kind_in = KindRead; rbyte_in = w_rd; len_in = '0; off_in = '0;
            state_in = ST_DONE;
         end
         ST_WU1: begin
            lo_in = w_rd; w_ra = oldest_ff + 1'b1; state_in = ST_WU2;
         end
         ST_WU2: begin
            key_in = {w_rd, lo_ff}; l_ra = oldest_ff; state_in = ST_WU3;
         end
         ST_WU3: begin
            h_we = 1'b1; h_wa = key_ff; h_wd = l_rd;
            l_we = 1'b1; l_wa = oldest_ff;
            w_we = 1'b1; w_wa = oldest_ff; w_wd = b_ff;
            w_ra = newest_ff; state_in = ST_WU4;
         end
         ST_WU4: begin
            key_in = {b_ff, new_lo};
            h_ra = {b_ff, new_lo}; t_ra = {b_ff, new_lo};
            state_in = ST_WU5;
         end
         ST_WU5: begin
            if (h_rd[PosW] == 1'b0) begin
               l_we = 1'b1; l_wa = t_rd; l_wd = {1'b0, newest_ff};
            end else begin
               h_we = 1'b1; h_wd = {1'b0, newest_ff};
            end
            t_we = 1'b1;
            newest_in = newest_ff + 1'b1; oldest_in = oldest_ff + 1'b1;
            state_in = ST_WU6;
         end
         ST_WU6: state_in = ST_IDLE;
         ST_SR1: begin
            len_in = '0; off_in = '0; steps_in = '0; kind_in = KindSearch;
            rbyte_in = '0;
            if (cnt_ff < CntW'(3)) begin
               cnt_in = '0; state_in = ST_DONE;
            end else begin k_ra = '0; state_in = ST_SR2; end
         end
         ST_SR2: begin
            lo_in = k_rd; k_ra = LookW'(1); state_in = ST_SR3;
         end
         ST_SR3: begin
            h_ra = {k_rd, lo_ff}; state_in = ST_SR4;
         end
         ST_SR4: begin
            c_in = h_rd; state_in = ST_SR5;
         end
         ST_SR5: begin
            if (c_ff[PosW] || steps_ff[PosW]) state_in = ST_SRA;
            else begin
               steps_in = steps_ff + 1'b1;
               idx = (len_ff == CntW'(MaxLook)) ? len_ff : len_ff;
               k_ra = idx[LookW-1:0];
               w_ra = cpos + PosW'(len_ff);
               l_ra = cpos;
               state_in = ST_SR6;
            end
         end
         ST_SR6: begin
            lo_in = l_rd[7:0];
            key_in = l_rd[PosW-1:0];
            b_in = {7'd0, l_rd[PosW]};
            if (k_rd == w_rd) begin
               cl_in = CntW'(2);
               k_ra = LookW'(2); w_ra = cpos + PosW'(2);
               state_in = ST_SR7;
            end else state_in = ST_SR9;
         end
         ST_SR7: begin
            if (cl_ff < cnt_ff && k_rd == w_rd) begin
               cl_in = cl_ff + 1'b1;
               idx = cl_ff + 1'b1;
               k_ra = idx[LookW-1:0];
               w_ra = cpos + PosW'(cl_ff) + 1'b1;
            end else state_in = ST_SR8;
         end
         ST_SR8: begin
            if (cl_ff > len_ff) begin len_in = cl_ff; off_in = cpos; end
            if (cl_ff == cnt_ff) state_in = ST_SRA;
            else state_in = ST_SR9;
         end
         ST_SR9: begin
            c_in = {b_ff[0], key_ff}; state_in = ST_SR5;
         end
         ST_SRA: begin
            if (len_ff > CntW'(2)) off_in = off_ff - oldest_ff;
            cnt_in = '0; state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; oldest_ff <= '0;
         newest_ff <= '1; cnt_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; oldest_ff <= oldest_in;
         newest_ff <= newest_in; cnt_ff <= cnt_in;
      end
      b_ff <= b_in; key_ff <= key_in; c_ff <= c_in; steps_ff <= steps_in;
      len_ff <= len_in; cl_ff <= cl_in; off_ff <= off_in; lo_ff <= lo_in;
      kind_ff <= kind_in; rbyte_ff <= rbyte_in;
   end

   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_result_kind = kind_ff;
   assign rsp_read_byte = rbyte_ff;
   assign rsp_match_length = len_ff;
   assign rsp_match_offset = off_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result shown while idle");
   a_done_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(MaxLook)) else $error("lookahead overflow");
   a_rd_len0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KindRead |-> rsp_match_length == '0)
      else $error("read with length");
endmodule

// ===== hdl/lzwmf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lzwmf_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== tb/sv/lz_window_match_finder_tb.sv =====
// Self-checking testbench for lz_window_match_finder: reads and chain searches are
// checked against an in-bench dictionary predictor that models writes; random start gaps.
// Depends on lzwmf_pkg and the lz_window_match_finder RTL.
module lz_window_match_finder_tb
   import lzwmf_pkg::*;
();

   typedef struct packed {
      logic [1:0]      mode;
      logic [7:0]      data_byte;
      logic            last;
      logic [PosW-1:0] read_index;
   } cmd_type;

   typedef struct packed {
      logic            kind;
      logic [7:0]      read_byte;
      logic [LenW-1:0] length;
      logic [PosW-1:0] offset;
   } rsp_type;

   localparam logic [LinkW-1:0] NoLink = 17'h10000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_mode = ModeRead;
   logic [7:0]        req_data_byte = 8'd0;
   logic              req_last = 1'b0;
   logic [PosW-1:0]   req_read_index = '0;
   logic              rsp_valid;
   logic              rsp_result_kind;
   logic [7:0]        rsp_read_byte;
   logic [LenW-1:0]   rsp_match_length;
   logic [PosW-1:0]   rsp_match_offset;

   lz_window_match_finder dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_data_byte(req_data_byte), .req_last(req_last),
      .req_read_index(req_read_index), .rsp_valid(rsp_valid),
      .rsp_result_kind(rsp_result_kind), .rsp_read_byte(rsp_read_byte),
      .rsp_match_length(rsp_match_length), .rsp_match_offset(rsp_match_offset)
   );

   logic [7:0]       window_mem [WinDepth];
   logic [LinkW-1:0] link_mem [WinDepth];
   logic [LinkW-1:0] head_mem [WinDepth];
   logic [PosW-1:0]  tail_mem [WinDepth];
   logic [PosW-1:0]  oldest_pos;
   logic [PosW-1:0]  newest_pos;
   logic [7:0]       look_buf [MaxLook];
   int unsigned      look_cnt;

   cmd_type pending_cmds[$];
   rsp_type expected_rsp[$];
   logic [7:0] written_hist[$];
   int     accepted_cnt = 0;
   int     error_cnt = 0;
   bit     start_next;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("lz_window_match_finder_tb: done, errors");
      $finish;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      error_cnt++;
   endtask

   function automatic void store_linked(input logic [7:0] b);
      logic [PosW-1:0] root;
      logic [PosW-1:0] root_next;
      logic [15:0]     key;
      root = oldest_pos;
      root_next = root + 16'd1;
      key = {window_mem[root_next], window_mem[root]};
      head_mem[key] = link_mem[root];
      link_mem[root] = NoLink;
      window_mem[root] = b;
      key = {window_mem[root], window_mem[newest_pos]};
      if (!head_mem[key][16])
         link_mem[tail_mem[key]] = {1'b0, newest_pos};
      else
         head_mem[key] = {1'b0, newest_pos};
      tail_mem[key] = newest_pos;
      newest_pos = newest_pos + 16'd1;
      oldest_pos = oldest_pos + 16'd1;
   endfunction

   function automatic void find_match(input int unsigned n, output rsp_type r);
      int unsigned best_len, best_pos, steps, cl;
      logic [LinkW-1:0] c;
      logic [PosW-1:0]  p;
      best_len = 0;
      best_pos = 0;
      steps = 0;
      r = '0;
      r.kind = KindSearch;
      if (n < 3) return;
      c = head_mem[{look_buf[1], look_buf[0]}];
      while (!c[16] && steps < WinDepth) begin
         p = c[PosW-1:0];
         steps++;
         if (look_buf[best_len] == window_mem[p + best_len[PosW-1:0]]) begin
            cl = 2;
            while (cl < n && look_buf[cl] == window_mem[p + cl[PosW-1:0]]) cl++;
            if (cl > best_len) begin
               best_len = cl;
               best_pos = 32'(p);
            end
            if (cl == n) break;
         end
         c = link_mem[p];
      end
      if (best_len > 2) best_pos = (best_pos + 32'h10000 - oldest_pos) & 32'hffff;
      r.length = best_len[LenW-1:0];
      r.offset = best_pos[PosW-1:0];
   endfunction

   function automatic void predict_step(input cmd_type cmd);
      rsp_type r;
      r = '0;
      case (cmd.mode)
         ModeWrUpd: store_linked(cmd.data_byte);
         ModeWrRaw: begin
            window_mem[oldest_pos] = cmd.data_byte;
            oldest_pos = oldest_pos + 16'd1;
         end
         ModeSearch: begin
            if (look_cnt < MaxLook) begin
               look_buf[look_cnt] = cmd.data_byte;
               look_cnt++;
            end
            if (cmd.last) begin
               find_match(look_cnt, r);
               look_cnt = 0;
               expected_rsp.push_back(r);
            end
         end
         default: begin
            r.kind = KindRead;
            r.read_byte = window_mem[cmd.read_index + oldest_pos];
            expected_rsp.push_back(r);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         start_next = start;
         if (start && !busy) begin
            predict_step(pending_cmds.pop_front());
            accepted_cnt++;
            start_next = 1'b0;
         end
         if (!start_next && pending_cmds.size() > 0 &&
             ((accepted_cnt >= 250 && accepted_cnt < 400) || $urandom_range(99) >= 32)) begin
            req_mode <= pending_cmds[0].mode;
            req_data_byte <= pending_cmds[0].data_byte;
            req_last <= pending_cmds[0].last;
            req_read_index <= pending_cmds[0].read_index;
            start_next = 1'b1;
         end
         start <= start_next;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            flag_mismatch("unexpected result, kind", rsp_result_kind, -1);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_result_kind !== want.kind)
               flag_mismatch("result_kind", rsp_result_kind, want.kind);
            if (rsp_read_byte !== want.read_byte)
               flag_mismatch("read_byte", rsp_read_byte, want.read_byte);
            if (rsp_match_length !== want.length)
               flag_mismatch("match_length", rsp_match_length, want.length);
            if (rsp_match_offset !== want.offset)
               flag_mismatch("match_offset", rsp_match_offset, want.offset);
         end
      end
   end

   task automatic push_cmd(input logic [1:0] mode, input logic [7:0] b, input logic last,
                           input logic [PosW-1:0] idx);
      cmd_type c;
      c.mode = mode;
      c.data_byte = b;
      c.last = last;
      c.read_index = idx;
      pending_cmds.push_back(c);
      if (mode == ModeWrUpd) written_hist.push_back(b);
   endtask

   task automatic push_search_rand(input int n, input bit from_hist);
      int base;
      logic [7:0] b;
      base = (written_hist.size() > n) ? $urandom_range(written_hist.size() - n - 1, 0) : 0;
      for (int i = 0; i < n; i++) begin
         if (from_hist && base + i < written_hist.size()) b = written_hist[base + i];
         else b = 8'($urandom_range(7));
         if (i == n - 1 && $urandom_range(3) == 0) b = 8'($urandom);
         push_cmd(ModeSearch, b, i == n - 1, PosW'($urandom));
      end
   endtask

   function automatic logic [7:0] pick_byte();
      return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(7));
   endfunction

   initial begin
      int pick, n, base;
      bit did_256, did_258;
      for (int i = 0; i < WinDepth; i++) begin
         window_mem[i] = 8'd0;
         link_mem[i] = NoLink;
         head_mem[i] = NoLink;
         tail_mem[i] = '0;
      end
      oldest_pos = 16'd0;
      newest_pos = 16'hffff;
      look_cnt = 0;
      did_256 = 0;
      did_258 = 0;

      push_cmd(ModeRead, 8'hff, 1'b1, 16'h0000);
      push_cmd(ModeRead, 8'h00, 1'b0, 16'hffff);
      push_cmd(ModeSearch, 8'h00, 1'b1, 16'h0);
      push_cmd(ModeSearch, 8'h00, 1'b0, 16'h0);
      push_cmd(ModeSearch, 8'hff, 1'b1, 16'h0);
      push_cmd(ModeSearch, 8'h00, 1'b0, 16'h0);
      push_cmd(ModeSearch, 8'h00, 1'b0, 16'h0);
      push_cmd(ModeSearch, 8'h00, 1'b1, 16'h0);
      push_cmd(ModeWrUpd, 8'h00, 1'b1, 16'hffff);
      push_cmd(ModeWrUpd, 8'hff, 1'b0, 16'h0);
      push_cmd(ModeWrUpd, 8'h00, 1'b0, 16'h0);
      push_cmd(ModeWrUpd, 8'hff, 1'b0, 16'h0);
      push_cmd(ModeWrUpd, 8'h00, 1'b0, 16'h0);
      push_cmd(ModeWrRaw, 8'hff, 1'b1, 16'hffff);
      push_cmd(ModeSearch, 8'h00, 1'b0, 16'h0);
      push_cmd(ModeSearch, 8'hff, 1'b0, 16'h0);
      push_cmd(ModeSearch, 8'h00, 1'b1, 16'h0);
      push_cmd(ModeSearch, 8'hff, 1'b0, 16'h0);
      push_cmd(ModeSearch, 8'h00, 1'b0, 16'h0);
      push_cmd(ModeSearch, 8'h11, 1'b1, 16'h0);
      push_cmd(ModeRead, 8'h00, 1'b0, 16'hfffb);
      push_cmd(ModeRead, 8'h00, 1'b0, 16'h0003);

      while (pending_cmds.size() < 720) begin
         pick = $urandom_range(99);
         if (!did_256 && pending_cmds.size() > 350) begin
            push_search_rand(256, 0);
            did_256 = 1;
         end else if (!did_258 && pending_cmds.size() > 600) begin
            push_search_rand(258, 0);
            did_258 = 1;
         end else if (pick < 50) begin
            n = $urandom_range(8, 1);
            if (written_hist.size() > 16 && $urandom_range(1)) begin
               base = $urandom_range(written_hist.size() - 9, 0);
               for (int i = 0; i < n; i++)
                  push_cmd(ModeWrUpd, written_hist[base + i], 1'($urandom),
                           PosW'($urandom));
            end else begin
               for (int i = 0; i < n; i++)
                  push_cmd(ModeWrUpd, pick_byte(), 1'($urandom), PosW'($urandom));
            end
         end else if (pick < 55) begin
            push_cmd(ModeWrRaw, pick_byte(), 1'($urandom), PosW'($urandom));
         end else if (pick < 60) begin
            push_search_rand($urandom_range(2, 1), 1);
         end else if (pick < 80) begin
            push_search_rand($urandom_range(12, 3), $urandom_range(3) != 0);
         end else if (pick < 85) begin
            push_cmd(ModeRead, 8'($urandom), 1'($urandom),
                     16'hffff - PosW'($urandom_range(3)));
         end else begin
            push_cmd(ModeRead, 8'($urandom), 1'($urandom), PosW'($urandom));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_cmds.size() > 0 || start) @(posedge clock);
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_cnt == 0 && expected_rsp.size() == 0)
         $display("lz_window_match_finder_tb: done, clean");
      else
         $display("lz_window_match_finder_tb: done, errors");
      $finish;
   end
endmodule
